### rtl/core/bcr_pkg.sv
// Shared types and constants for the button combination repeat classifier.
package bcr_pkg;

    localparam int HOLD_W  = 16;
    localparam int RPT_W   = 8;
    localparam int CODE_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESH   = 3'd4;

    // Configuration reset values
    localparam logic [RPT_W-1:0]  RST_INITIAL_DELAY = 8'd6;
    localparam logic [RPT_W-1:0]  RST_SLOW_RATE     = 8'd8;
    localparam logic [RPT_W-1:0]  RST_FAST_RATE     = 8'd2;
    localparam logic [HOLD_W-1:0] RST_FAST_THRESH   = 16'd40;
    localparam logic [HOLD_W-1:0] RST_LONG_THRESH   = 16'd60;

    // Operation codes
    localparam logic OP_CHANGE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Event codes
    localparam logic [CODE_W-1:0] EV_ALL        = 4'd0;
    localparam logic [CODE_W-1:0] EV_B1B2_LONG  = 4'd1;
    localparam logic [CODE_W-1:0] EV_B3B1       = 4'd2;
    localparam logic [CODE_W-1:0] EV_B3B2       = 4'd3;
    localparam logic [CODE_W-1:0] EV_B1         = 4'd4;
    localparam logic [CODE_W-1:0] EV_B2         = 4'd5;
    localparam logic [CODE_W-1:0] EV_B3_LONG    = 4'd6;
    localparam logic [CODE_W-1:0] EV_B3_SHORT   = 4'd7;
    localparam logic [CODE_W-1:0] EV_B1B2_SHORT = 4'd8;
    localparam logic [CODE_W-1:0] EV_RELEASED   = 4'd9;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    typedef struct packed {
        logic [RPT_W-1:0]  initial_delay;
        logic [RPT_W-1:0]  slow_rate;
        logic [RPT_W-1:0]  fast_rate;
        logic [HOLD_W-1:0] fast_thresh;
        logic [HOLD_W-1:0] long_thresh;
    } cfg_t;

    typedef struct packed {
        logic              armed;
        logic [2:0]        held;
        logic [HOLD_W-1:0] hold_count;
        logic [RPT_W-1:0]  repeat_count;
        logic              long_flag;
        logic              fast_flag;
    } state_t;

    typedef struct packed {
        logic operation;
        logic button_one;
        logic button_two;
        logic button_three;
    } item_t;

    typedef struct packed {
        logic              fire;
        logic [CODE_W-1:0] event_code;
        logic              fast_mode;
    } result_t;

endpackage

### rtl/core/bcr_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface bcr_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic button_one;
    logic button_two;
    logic button_three;

    modport source (output valid, operation, button_one, button_two, button_three,
                    input ready);
    modport sink   (input valid, operation, button_one, button_two, button_three,
                    output ready);
endinterface

interface bcr_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic       fast_mode;

    modport source (output valid, event_code, fast_mode, input ready);
    modport sink   (input valid, event_code, fast_mode, output ready);
endinterface

interface bcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/button_combo_repeat_classifier_core.sv
// Top level of the three-button combination, long-press and auto-repeat classifier.
//
// Channels:
//   in_ch  - input beats: operation (0 = change, arms the tick timer;
//            1 = tick) and the three pressed levels.
//   out_ch - result beats: event_code and fast_mode. A tick that fires no
//            event, a change beat and a tick while disarmed give no beat.
//   cfg    - register writes by index (0 initial delay, 1 slow rate,
//            2 fast rate, 3 fast threshold, 4 long threshold); always ready.
//            Write only while the block is idle.
// Path: an accepted input beat is captured in the input register, then its
// result lands in the output register. Throughput: one beat per cycle while
// out_ch does not stall; the per-beat work is a few compares and increments
// between the input and output registers.
// Stall: when out_ch is not ready the output register holds its beat; the
// input register still drains if its beat makes no result, else it holds and
// in_ch.ready drops. Every state change is committed as the input register
// advances, so stalls never lose or repeat work.
// Reset: all tracking state clears, the block is disarmed and the
// configuration registers return to their defaults (6, 8, 2, 40, 60).
module button_combo_repeat_classifier_core (
    input logic           clk,
    input logic           rst_n,
    bcr_in_if.sink        in_ch,
    bcr_out_if.source     out_ch,
    bcr_cfg_if.sink       cfg
);
    import bcr_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t step_res;
    logic    out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic    out_fast_reg;
    logic    out_free;
    logic    item_adv;

    // Output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ch.ready;
    // Advance the input register when its beat has somewhere to go.
    assign item_adv = item_valid_reg && (out_free || !step_res.fire);
    assign in_ch.ready = !item_valid_reg || item_adv;
    assign cfg.ready = 1'b1;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.event_code = out_code_reg;
    assign out_ch.fast_mode  = out_fast_reg;

    bcr_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay <= RST_INITIAL_DELAY;
            cfg_reg.slow_rate     <= RST_SLOW_RATE;
            cfg_reg.fast_rate     <= RST_FAST_RATE;
            cfg_reg.fast_thresh   <= RST_FAST_THRESH;
            cfg_reg.long_thresh   <= RST_LONG_THRESH;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                CFG_INITIAL_DELAY: cfg_reg.initial_delay <= cfg.wdata[RPT_W-1:0];
                CFG_SLOW_RATE:     cfg_reg.slow_rate     <= cfg.wdata[RPT_W-1:0];
                CFG_FAST_RATE:     cfg_reg.fast_rate     <= cfg.wdata[RPT_W-1:0];
                CFG_FAST_THRESH:   cfg_reg.fast_thresh   <= cfg.wdata;
                CFG_LONG_THRESH:   cfg_reg.long_thresh   <= cfg.wdata;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // Input register: capture a beat whenever the slot frees up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ch.ready)
            item_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.operation    <= in_ch.operation;
            item_reg.button_one   <= in_ch.button_one;
            item_reg.button_two   <= in_ch.button_two;
            item_reg.button_three <= in_ch.button_three;
        end
    end

    // Tracking state commits as the input beat advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (item_adv)
            state_reg <= state_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_adv && step_res.fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_adv && step_res.fire)
        begin
            out_code_reg <= step_res.event_code;
            out_fast_reg <= step_res.fast_mode;
        end
    end

    // Disarmed means nothing is being tracked.
    a_disarmed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.armed |-> (state_reg.hold_count == '0) && (state_reg.held == 3'b000))
        else $error("tracking state left while disarmed");

    // No hold ticks means no flags and no repeat progress.
    a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.hold_count == '0) |->
            !state_reg.long_flag && !state_reg.fast_flag && (state_reg.repeat_count == '0))
        else $error("flags set without any hold tick");

    // Release events always report fast mode off.
    a_release_fast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_code_reg == EV_B3_SHORT) || (out_code_reg == EV_B1B2_SHORT)
            || (out_code_reg == EV_RELEASED)) |-> !out_fast_reg)
        else $error("release event with fast mode set");

    // A firing beat that advances lands in the output register.
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item_adv && step_res.fire) |=> out_valid_reg)
        else $error("fired result lost");

endmodule

### rtl/core/bcr_step.sv
// Next-state and event logic for one input item.
module bcr_step (
    input  bcr_pkg::cfg_t    cfg,
    input  bcr_pkg::state_t  cur,
    input  bcr_pkg::item_t   item,
    output bcr_pkg::state_t  nxt,
    output bcr_pkg::result_t res
);
    import bcr_pkg::*;

    logic [2:0]        btn;
    logic [HOLD_W-1:0] hold_inc;
    logic [RPT_W-1:0]  rpt_inc;
    logic              long_upd;
    logic              fast_upd;
    logic [RPT_W-1:0]  rate;
    logic              fire;

    assign btn      = {item.button_three, item.button_two, item.button_one};
    assign hold_inc = (cur.hold_count == HOLD_MAX) ? cur.hold_count
                                                   : cur.hold_count + 1'b1;
    assign rpt_inc  = cur.repeat_count + 1'b1;
    assign long_upd = cur.long_flag | (hold_inc > cfg.long_thresh);
    assign fast_upd = cur.fast_flag | (hold_inc > cfg.fast_thresh);
    assign rate     = fast_upd ? cfg.fast_rate : cfg.slow_rate;
    assign fire     = (hold_inc == HOLD_W'(1))
                   || ((rpt_inc >= cfg.initial_delay) && (rpt_inc >= rate));

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (item.operation == OP_CHANGE)
        begin
            nxt.armed = 1'b1;
        end
        else if (cur.armed && (btn != 3'b000))
        begin
            nxt.held         = btn;
            nxt.hold_count   = hold_inc;
            nxt.repeat_count = fire ? '0 : rpt_inc;
            nxt.long_flag    = long_upd;
            nxt.fast_flag    = fast_upd;
            res.fast_mode    = fast_upd;
            if (fire)
            begin
                priority if (btn == 3'b111)
                begin
                    res.fire = 1'b1;
                    res.event_code = EV_ALL;
                end
                else if (btn == 3'b011)
                begin
                    // pair of first two buttons reports only once long
                    res.fire = long_upd;
                    res.event_code = EV_B1B2_LONG;
                    nxt.long_flag = 1'b0;
                end
                else if (btn == 3'b101)
                begin
                    res.fire = 1'b1;
                    res.event_code = EV_B3B1;
                end
                else if (btn == 3'b110)
                begin
                    res.fire = 1'b1;
                    res.event_code = EV_B3B2;
                end
                else if (btn[0])
                begin
                    res.fire = 1'b1;
                    res.event_code = EV_B1;
                end
                else if (btn[1])
                begin
                    res.fire = 1'b1;
                    res.event_code = EV_B2;
                end
                else
                begin
                    res.fire = long_upd;
                    res.event_code = EV_B3_LONG;
                    nxt.long_flag = 1'b0;
                end
            end
        end
        else if (cur.armed)
        begin
            // release: classify what was held, then clear and disarm
            res.fire = 1'b1;
            priority if ((cur.held == 3'b100) && !cur.long_flag)
                res.event_code = EV_B3_SHORT;
            else if ((cur.held[1:0] == 2'b11) && !cur.long_flag)
                res.event_code = EV_B1B2_SHORT;
            else
                res.event_code = EV_RELEASED;
            nxt = '0;
        end
    end

endmodule
